// ----- rtl/hpc_pkg.sv -----
package hpc_pkg;

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_FETCH = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_MAX  = 2'd0;
    localparam logic [1:0] VERDICT_MIN  = 2'd1;
    localparam logic [1:0] VERDICT_NONE = 2'd2;

    // Report phases
    localparam logic [1:0] PHASE_PATHS   = 2'd0;
    localparam logic [1:0] PHASE_VERDICT = 2'd1;
    localparam logic [1:0] PHASE_DONE    = 2'd2;

    typedef logic [1:0]         t_code;
    typedef logic signed [31:0] t_word;

endpackage

// ----- rtl/hpc_if.sv -----
// Request channel: load, fetch or clear
interface hpc_req_if import hpc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code req_type;
    t_word node_value;

    modport source (output valid, output req_type, output node_value, input ready);
    modport sink   (input valid, input req_type, input node_value, output ready);
endinterface

// Result channel: path keys, verdict, done
interface hpc_rsp_if import hpc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code result_kind;
    t_word path_value;
    logic  end_of_path;
    t_code verdict;

    modport source (output valid, output result_kind, output path_value,
                    output end_of_path, output verdict, input ready);
    modport sink   (input valid, input result_kind, input path_value,
                    input end_of_path, input verdict, output ready);
endinterface

// ----- rtl/hpc_ram.sv -----
module hpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/heap_path_and_type_check_top.sv -----
// Heap checker with root-to-leaf path listing.
// Requests arrive on i_req (valid/ready): load appends a key to the tree in
// level order, fetch asks for the next result, clear empties the tree.
// Results leave on o_rsp (valid/ready): first every root-to-leaf path, one
// key per fetch, leaves taken right before left; then the heap verdict; then
// a done marker on every further fetch. Loads and clears give no result.
// Timing: a load takes the store write, then the parent compare in S_LOAD.
// A path fetch reads its key from the node store on acceptance and presents
// it from S_DATA through the output register. The first fetch first walks
// down to the rightmost leaf, one level a cycle, before that read. After the
// last key of a path the block climbs and descends to the next leaf, one
// level a cycle, before the next request is taken. Verdict and done results
// appear the cycle after acceptance. The node store has one read port, which
// sets this order of steps.
// Reset (and a clear request) empties the tree and restarts the report; the
// node store is not swept, entries above the count are never read.
// A result waits in the output register while the receiver stalls; no new
// request is taken until it has been consumed.
module heap_path_and_type_check_top import hpc_pkg::*; #(
    parameter int MAX_NODES   = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpc_req_if.sink   i_req,
    hpc_rsp_if.source o_rsp
);

    localparam int KEY_W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int DEP_W  = $clog2(CNT_W);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_NODES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DESC  = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;
    localparam logic [2:0] S_CLIMB = 3'd5;

    logic [2:0]              r_state,   n_state;
    logic [CNT_W-1:0]        r_count,   n_count;
    logic                    r_max_ok,  n_max_ok;
    logic                    r_min_ok,  n_min_ok;
    logic [CNT_W-1:0]        r_leaf,    n_leaf;
    logic [DEP_W-1:0]        r_depth,   n_depth;
    logic [DEP_W-1:0]        r_level,   n_level;
    logic [1:0]              r_phase,   n_phase;
    logic                    r_emit,    n_emit;
    logic                    r_has_par, n_has_par;
    logic signed [KEY_W-1:0] r_key,     n_key;
    logic                    r_out_valid, n_out_valid;
    t_code                   r_out_kind,  n_out_kind;
    t_word                   r_out_value, n_out_value;
    logic                    r_out_end,   n_out_end;
    t_code                   r_out_verd,  n_out_verd;

    logic                    w_ready;
    logic                    w_accept;
    logic                    w_out_take;
    logic signed [KEY_W-1:0] w_key;
    logic signed [KEY_W-1:0] w_rdata;
    t_code                   w_verdict;
    logic [CNT_W-1:0]        w_k;
    logic [DEP_W-1:0]        w_shift;
    logic [CNT_W-1:0]        w_idx;
    logic [ADDR_W-1:0]       w_path_addr;
    logic [ADDR_W-1:0]       w_par_addr;
    logic [ADDR_W-1:0]       w_raddr;
    logic [CNT_W:0]          w_down_l;
    logic [CNT_W:0]          w_down_r;
    logic [CNT_W:0]          w_cnt_ext;
    logic                    w_load_ok;
    logic                    w_we;

    // Handshakes
    assign w_ready    = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept   = i_req.valid && w_ready;
    assign w_out_take = r_out_valid && o_rsp.ready;

    // Key narrowing and verdict
    assign w_key     = i_req.node_value[KEY_W-1:0];
    assign w_verdict = r_max_ok ? VERDICT_MAX : (r_min_ok ? VERDICT_MIN : VERDICT_NONE);

    // Node on the current path and parent of the next load
    assign w_k         = r_count + 1'b1;
    assign w_shift     = r_depth - r_level;
    assign w_idx       = r_leaf >> w_shift;
    assign w_path_addr = ADDR_W'(w_idx - 1'b1);
    assign w_par_addr  = ADDR_W'((w_k >> 1) - 1'b1);

    // Child indices for the descent
    assign w_down_l  = {r_leaf, 1'b0};
    assign w_down_r  = {r_leaf, 1'b1};
    assign w_cnt_ext = {1'b0, r_count};

    assign w_load_ok = (r_leaf == '0) && (r_phase == PHASE_PATHS) && (r_count != FULL);
    assign w_we      = w_accept && (i_req.req_type == REQ_LOAD) && w_load_ok;
    assign w_raddr   = ((r_state == S_IDLE) && (i_req.req_type == REQ_LOAD))
                       ? w_par_addr : w_path_addr;

    hpc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_NODES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_max_ok    = r_max_ok;
        n_min_ok    = r_min_ok;
        n_leaf      = r_leaf;
        n_depth     = r_depth;
        n_level     = r_level;
        n_phase     = r_phase;
        n_emit      = r_emit;
        n_has_par   = r_has_par;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_verd  = r_out_verd;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_LOAD: begin
                            if (w_load_ok) begin
                                n_count   = w_k;
                                n_key     = w_key;
                                n_has_par = (r_count != '0);
                                n_state   = S_LOAD;
                            end
                        end
                        REQ_FETCH: begin
                            if ((r_phase == PHASE_PATHS) && (r_leaf != '0)) begin
                                n_state = S_DATA;
                            end else if ((r_phase == PHASE_PATHS) && (r_count != '0)) begin
                                n_leaf  = CNT_W'(1);
                                n_depth = '0;
                                n_level = '0;
                                n_emit  = 1'b1;
                                n_state = S_DESC;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_value = '0;
                                n_out_end   = 1'b0;
                                if (r_phase == PHASE_DONE) begin
                                    n_out_kind = KIND_DONE;
                                    n_out_verd = VERDICT_MAX;
                                end else begin
                                    n_out_kind = KIND_VERDICT;
                                    n_out_verd = w_verdict;
                                    n_phase    = PHASE_DONE;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_max_ok = 1'b1;
                            n_min_ok = 1'b1;
                            n_leaf   = '0;
                            n_depth  = '0;
                            n_level  = '0;
                            n_phase  = PHASE_PATHS;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Compare the new key against its parent
            S_LOAD: begin
                if (r_has_par) begin
                    if (w_rdata < r_key) begin
                        n_max_ok = 1'b0;
                    end
                    if (w_rdata > r_key) begin
                        n_min_ok = 1'b0;
                    end
                end
                n_state = S_IDLE;
            end
            // Walk down, right child where present
            S_DESC: begin
                if (w_down_l <= w_cnt_ext) begin
                    n_leaf  = (w_down_r <= w_cnt_ext) ? CNT_W'(w_down_r) : CNT_W'(w_down_l);
                    n_depth = r_depth + 1'b1;
                end else begin
                    n_state = r_emit ? S_ISSUE : S_IDLE;
                end
            end
            S_ISSUE: begin
                n_state = S_DATA;
            end
            // Present the key read for this fetch
            S_DATA: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_PATH;
                n_out_value = t_word'(w_rdata);
                n_out_end   = (r_level == r_depth);
                n_out_verd  = VERDICT_MAX;
                if (r_level == r_depth) begin
                    n_level = '0;
                    n_state = S_CLIMB;
                end else begin
                    n_level = r_level + 1'b1;
                    n_state = S_IDLE;
                end
            end
            // Climb while a left child, then step to the left sibling
            S_CLIMB: begin
                if ((r_leaf > CNT_W'(1)) && !r_leaf[0]) begin
                    n_leaf  = r_leaf >> 1;
                    n_depth = r_depth - 1'b1;
                end else if (r_leaf <= CNT_W'(1)) begin
                    n_leaf  = '0;
                    n_depth = '0;
                    n_phase = PHASE_VERDICT;
                    n_state = S_IDLE;
                end else begin
                    n_leaf  = r_leaf - 1'b1;
                    n_emit  = 1'b0;
                    n_state = S_DESC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_ok    <= 1'b1;
            r_min_ok    <= 1'b1;
            r_leaf      <= '0;
            r_depth     <= '0;
            r_level     <= '0;
            r_phase     <= PHASE_PATHS;
            r_emit      <= 1'b0;
            r_has_par   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max_ok    <= n_max_ok;
            r_min_ok    <= n_min_ok;
            r_leaf      <= n_leaf;
            r_depth     <= n_depth;
            r_level     <= n_level;
            r_phase     <= n_phase;
            r_emit      <= n_emit;
            r_has_par   <= n_has_par;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_verd  <= n_out_verd;
    end

    assign i_req.ready       = w_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.path_value  = r_out_value;
    assign o_rsp.end_of_path = r_out_end;
    assign o_rsp.verdict     = r_out_verd;

endmodule

// ----- rtl/hpc_checker.sv -----
module hpc_checker import hpc_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_req_ready,
    input logic  i_rsp_valid,
    input logic  i_rsp_ready,
    input t_code i_result_kind,
    input t_word i_path_value,
    input logic  i_end_of_path,
    input t_code i_verdict
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !i_req_ready)
        else $error("request taken while result stalled");

    // Hold a stalled result
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_result_kind) && $stable(i_path_value)
         && $stable(i_end_of_path) && $stable(i_verdict)))
        else $error("stalled result changed");

    // Path fields are zero outside path results
    a_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_result_kind != KIND_PATH)) |->
        ((i_path_value == '0) && !i_end_of_path))
        else $error("path fields set on non-path result");

    // Verdict is zero outside verdict results
    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_result_kind != KIND_VERDICT)) |-> (i_verdict == VERDICT_MAX))
        else $error("verdict set on non-verdict result");

endmodule

bind heap_path_and_type_check_top hpc_checker u_hpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_result_kind (o_rsp.result_kind),
    .i_path_value  (o_rsp.path_value),
    .i_end_of_path (o_rsp.end_of_path),
    .i_verdict     (o_rsp.verdict)
);
